### rtl/core/lkv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_pkg: shared definitions for the LRU key/value cache
// Field widths, request codes, register reset value and the cell control
// bundle that the top level hands to every cell of the chain.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int MAX_ENTRIES_DEF = 16;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Request codes carried on in_tuser.
  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_SET = 1'b1;

  // Value returned by a lookup that finds nothing.
  localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

  // Per-cycle control broadcast to all cells.
  typedef struct packed {
    logic cmp_en;  // capture the key compare result
    logic upd_en;  // shift the recency chain
  } cell_ctl_t;

endpackage
`default_nettype wire

### rtl/core/lkv_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_cell: one entry of the recency-ordered chain
// Holds a key, a value and a valid bit. The position in the chain is the
// recency rank. On an update the cell takes its neighbor's entry when its
// position is at or below the shift limit.
// ----------------------------------------------------------------------------
module lkv_cell #(
  parameter int IDX_W    = 4,
  parameter int CELL_IDX = 0
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire lkv_pkg::cell_ctl_t      ctl,
  input  wire [IDX_W-1:0]              lim,
  input  wire [lkv_pkg::KEY_W-1:0]     cmp_key,
  input  wire [lkv_pkg::KEY_W-1:0]     prv_key,
  input  wire [lkv_pkg::VAL_W-1:0]     prv_value,
  input  wire                          prv_valid,
  output logic [lkv_pkg::KEY_W-1:0]    key_o,
  output logic [lkv_pkg::VAL_W-1:0]    value_o,
  output logic                         valid_o,
  output logic                         match_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [lkv_pkg::KEY_W-1:0] key_r;
  logic [lkv_pkg::VAL_W-1:0] value_r;
  logic                      valid_r;
  logic                      match_r;
  logic                      take;

  assign take = ctl.upd_en && (MY_IDX <= lim);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      if (ctl.cmp_en) begin
        match_r <= valid_r && (key_r == cmp_key);
      end
      if (take) begin
        valid_r <= prv_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      key_r   <= prv_key;
      value_r <= prv_value;
    end
  end

  assign key_o   = key_r;
  assign value_o = value_r;
  assign valid_o = valid_r;
  assign match_o = match_r;

endmodule
`default_nettype wire

### rtl/core/lru_key_value_cache.sv
`timescale 1ns / 1ps
`default_nettype none
// Each request beat makes a match-then-shift pass through the cell chain: capture
// (idle), key compare in every cell (match), chain shift (update). No new beat is
// taken until the pass ends; a lookup holds in update for a free output register.
// A lookup result may wait in the output register while the next beat is taken.
// Reset is synchronous and active low: it clears every valid bit, occupancy and
// the request state at once and loads capacity with 16; no clearing pass.
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key/value store with LRU replacement
// A chain of cells kept in recency order: cell 0 is the most recent entry and
// the valid cells always form a prefix of the chain.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // Configuration: capacity register.
  input  wire                          cfg_wr_en,
  input  wire [lkv_pkg::CAP_W-1:0]     cfg_wr_data,
  // Request channel.
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire [63:0]                   in_tdata,  // [31:0] key, [63:32] value
  input  wire                          in_tuser,  // [0] mode (0 get, 1 set)
  // Result channel.
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [31:0]                  out_tdata, // [31:0] read_value
  output logic                         out_tuser  // [0] hit
);

  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OCC_W  = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W  = (OCC_W > lkv_pkg::CAP_W) ? OCC_W : lkv_pkg::CAP_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_ENTRIES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE
  } state_t;

  state_t                       state_r;
  logic                         req_mode_r;
  logic [lkv_pkg::KEY_W-1:0]    req_key_r;
  logic [lkv_pkg::VAL_W-1:0]    req_value_r;
  logic [OCC_W-1:0]             occ_r;
  logic [lkv_pkg::CAP_W-1:0]    cap_r;
  logic                         out_tvalid_r;
  logic [lkv_pkg::VAL_W-1:0]    out_tdata_r;
  logic                         out_tuser_r;

  // Chain taps, each read at its own fixed place.
  logic [lkv_pkg::KEY_W-1:0]    key_a   [MAX_ENTRIES];
  logic [lkv_pkg::VAL_W-1:0]    value_a [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]       valid_vec;
  logic [MAX_ENTRIES-1:0]       match_vec;

  lkv_pkg::cell_ctl_t           ctl;
  logic [IDX_W-1:0]             lim;
  logic                         hit_any;
  logic [IDX_W-1:0]             hit_idx;
  logic [lkv_pkg::VAL_W-1:0]    hit_value;
  logic [lkv_pkg::VAL_W-1:0]    head_value;
  logic [CMP_W-1:0]             eff_cap;
  logic                         full;
  logic                         is_set;
  logic                         out_free;
  logic                         proceed;

  // --------------------------------------------------------------------------
  // Hit selection. At most one cell matches because keys are unique among the
  // valid cells, so the index and the value reduce with plain OR trees.
  // --------------------------------------------------------------------------
  always_comb begin
    hit_any   = 1'b0;
    hit_idx   = '0;
    hit_value = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_any   = hit_any | match_vec[i];
      hit_idx   = hit_idx | (match_vec[i] ? IDX_W'(i) : '0);
      hit_value = hit_value | (match_vec[i] ? value_a[i] : '0);
    end
  end

  // Capacity zero acts as one; anything above the chain length saturates.
  always_comb begin
    eff_cap = CMP_W'(cap_r);
    if (eff_cap == '0) begin
      eff_cap = CMP_W'(1);
    end else if (eff_cap > MAX_CMP) begin
      eff_cap = MAX_CMP;
    end
  end

  assign full     = CMP_W'(occ_r) >= eff_cap;
  assign is_set   = (req_mode_r == lkv_pkg::MODE_SET);
  assign out_free = !out_tvalid_r || out_tready;
  // A lookup only finishes once the output register can take its result.
  assign proceed  = (state_r == ST_UPDATE) && (is_set || out_free);

  // Shift limit: a hit moves its entry to the head; a set miss with room pushes
  // the whole prefix down; a set miss when full drops the least recent entry.
  always_comb begin
    if (hit_any) begin
      lim = hit_idx;
    end else if (!full) begin
      lim = IDX_W'(occ_r);
    end else begin
      lim = IDX_W'(occ_r - OCC_W'(1));
    end
  end

  assign head_value = is_set ? req_value_r : hit_value;
  assign ctl.cmp_en = (state_r == ST_MATCH);
  assign ctl.upd_en = proceed && (hit_any || is_set);

  // --------------------------------------------------------------------------
  // The cell chain. Cell 0 is fed by the head entry built from the request.
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic [lkv_pkg::KEY_W-1:0] prv_key;
    logic [lkv_pkg::VAL_W-1:0] prv_value;
    logic                      prv_valid;

    if (g == 0) begin : g_head
      assign prv_key   = req_key_r;
      assign prv_value = head_value;
      assign prv_valid = 1'b1;
    end else begin : g_link
      assign prv_key   = key_a[g-1];
      assign prv_value = value_a[g-1];
      assign prv_valid = valid_vec[g-1];
    end

    lkv_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .lim       (lim),
      .cmp_key   (req_key_r),
      .prv_key   (prv_key),
      .prv_value (prv_value),
      .prv_valid (prv_valid),
      .key_o     (key_a[g]),
      .value_o   (value_a[g]),
      .valid_o   (valid_vec[g]),
      .match_o   (match_vec[g])
    );
  end

  // --------------------------------------------------------------------------
  // Sequencer, request capture, occupancy, capacity and output register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      occ_r        <= '0;
      cap_r        <= lkv_pkg::CAP_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            state_r <= ST_MATCH;
          end
        end
        ST_MATCH: begin
          state_r <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (proceed) begin
            state_r <= ST_IDLE;
            if (is_set) begin
              if (!hit_any && !full) begin
                occ_r <= occ_r + OCC_W'(1);
              end
            end else begin
              out_tvalid_r <= 1'b1;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && in_tvalid) begin
      req_mode_r  <= in_tuser;
      req_key_r   <= in_tdata[31:0];
      req_value_r <= in_tdata[63:32];
    end
    if (proceed && !is_set) begin
      out_tdata_r <= hit_any ? hit_value : lkv_pkg::MISS_VALUE;
      out_tuser_r <= hit_any;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTH
  // Keys are unique among valid cells, so no two cells can report a match.
  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_vec))
    else $error("more than one cell matched the request key");

  // The occupancy counter tracks the number of valid cells.
  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(occ_r))
    else $error("occupancy does not match the valid cells");

  // A result beat appears only when a lookup finishes its update cycle.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == ST_UPDATE))
    else $error("result beat raised outside the update cycle");

  // A taken request beat always starts a compare cycle.
  a_accept_match: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_MATCH))
    else $error("accepted request did not enter the compare cycle");
`endif

endmodule
`default_nettype wire
